/* sv/ssu_pkg.sv */
package ssu_pkg;

    typedef logic signed [63:0] t_q;

    localparam int SAL_W = 17;
    localparam int TMP_W = 17;
    localparam int PRS_W = 18;
    localparam int SPD_W = 21;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 24;

    localparam int QMAC_LAT = 4;
    localparam int ROOT_STEPS = 32;
    localparam int T_DEG = 5;
    localparam int P_DEG = 3;
    localparam int PREP_LAT = 3;
    localparam int POLY_LAT = QMAC_LAT * (T_DEG + P_DEG);
    localparam int ROOT_LAT = ROOT_STEPS + QMAC_LAT;
    localparam int LAT = PREP_LAT + ROOT_LAT + QMAC_LAT + 2;

    localparam logic [SPD_W-1:0] SPD_MAX = '1;

    // floor((pv << 35 + 2) / 5) = pv * P_MUL + floor((3 * pv + 2) / 5)
    localparam logic [32:0] P_MUL = 33'd6871947673;
    localparam logic [21:0] DIV5_MUL = 22'd3355444;

    localparam int G_CW = 0;
    localparam int G_A = 1;
    localparam int G_B = 2;
    localparam int G_D = 3;

    // [poly][power of P][power of T], Q40
    localparam t_q COEF [4][4][6] = '{
        '{
            '{ t_q'(((64'd1402388 << 40) + 64'd1000 / 2) / 64'd1000),
               t_q'(((64'd503711 << 40) + 64'd100000 / 2) / 64'd100000),
               t_q'(64'd0 - ((64'd580852 << 40) + 64'd10000000 / 2) / 64'd10000000),
               t_q'(((64'd33420 << 40) + 64'd100000000 / 2) / 64'd100000000),
               t_q'(64'd0 - ((64'd147800 << 40) + 64'd100000000000 / 2)
                    / 64'd100000000000),
               t_q'(((64'd31464 << 40) + 64'd10000000000000 / 2) / 64'd10000000000000) },
            '{ t_q'(((64'd153563 << 40) + 64'd1000000 / 2) / 64'd1000000),
               t_q'(((64'd68982 << 40) + 64'd100000000 / 2) / 64'd100000000),
               t_q'(64'd0 - ((64'd81788 << 40) + 64'd10000000000 / 2) / 64'd10000000000),
               t_q'(((64'd13621 << 40) + 64'd100000000000 / 2) / 64'd100000000000),
               t_q'(64'd0 - ((64'd61185 << 40) + 64'd100000000000000 / 2)
                    / 64'd100000000000000),
               t_q'(0) },
            '{ t_q'(((64'd31260 << 40) + 64'd1000000000 / 2) / 64'd1000000000),
               t_q'(64'd0 - ((64'd17107 << 40) + 64'd10000000000 / 2) / 64'd10000000000),
               t_q'(((64'd25974 << 40) + 64'd1000000000000 / 2) / 64'd1000000000000),
               t_q'(64'd0 - ((64'd25335 << 40) + 64'd100000000000000 / 2)
                    / 64'd100000000000000),
               t_q'(((64'd10405 << 40) + 64'd10000000000000000 / 2)
                    / 64'd10000000000000000),
               t_q'(0) },
            '{ t_q'(64'd0 - ((64'd97729 << 40) + 64'd10000000000000 / 2)
                    / 64'd10000000000000),
               t_q'(((64'd38504 << 40) + 64'd100000000000000 / 2) / 64'd100000000000000),
               t_q'(64'd0 - ((64'd23643 << 40) + 64'd10000000000000000 / 2)
                    / 64'd10000000000000000),
               t_q'(0), t_q'(0), t_q'(0) }
        },
        '{
            '{ t_q'(((64'd1389 << 40) + 64'd1000 / 2) / 64'd1000),
               t_q'(64'd0 - ((64'd1262 << 40) + 64'd100000 / 2) / 64'd100000),
               t_q'(((64'd7166 << 40) + 64'd100000000 / 2) / 64'd100000000),
               t_q'(((64'd2008 << 40) + 64'd1000000000 / 2) / 64'd1000000000),
               t_q'(64'd0 - ((64'd321 << 40) + 64'd10000000000 / 2) / 64'd10000000000),
               t_q'(0) },
            '{ t_q'(((64'd94742 << 40) + 64'd1000000000 / 2) / 64'd1000000000),
               t_q'(64'd0 - ((64'd12583 << 40) + 64'd1000000000 / 2) / 64'd1000000000),
               t_q'(64'd0 - ((64'd64928 << 40) + 64'd1000000000000 / 2)
                    / 64'd1000000000000),
               t_q'(((64'd10515 << 40) + 64'd1000000000000 / 2) / 64'd1000000000000),
               t_q'(64'd0 - ((64'd20142 << 40) + 64'd100000000000000 / 2)
                    / 64'd100000000000000),
               t_q'(0) },
            '{ t_q'(64'd0 - ((64'd39064 << 40) + 64'd100000000000 / 2)
                    / 64'd100000000000),
               t_q'(((64'd91061 << 40) + 64'd10000000000000 / 2) / 64'd10000000000000),
               t_q'(64'd0 - ((64'd16009 << 40) + 64'd100000000000000 / 2)
                    / 64'd100000000000000),
               t_q'(((64'd7994 << 40) + 64'd1000000000000000 / 2) / 64'd1000000000000000),
               t_q'(0), t_q'(0) },
            '{ t_q'(((64'd1100 << 40) + 64'd10000000000000 / 2) / 64'd10000000000000),
               t_q'(((64'd6651 << 40) + 64'd1000000000000000 / 2) / 64'd1000000000000000),
               t_q'(64'd0 - ((64'd3391 << 40) + 64'd10000000000000000 / 2)
                    / 64'd10000000000000000),
               t_q'(0), t_q'(0), t_q'(0) }
        },
        '{
            '{ t_q'(64'd0 - ((64'd1922 << 40) + 64'd100000 / 2) / 64'd100000),
               t_q'(64'd0 - ((64'd442 << 40) + 64'd10000000 / 2) / 64'd10000000),
               t_q'(0), t_q'(0), t_q'(0), t_q'(0) },
            '{ t_q'(((64'd73637 << 40) + 64'd1000000000 / 2) / 64'd1000000000),
               t_q'(((64'd17950 << 40) + 64'd100000000000 / 2) / 64'd100000000000),
               t_q'(0), t_q'(0), t_q'(0), t_q'(0) },
            '{ t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0) },
            '{ t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0) }
        },
        '{
            '{ t_q'(((64'd1727 << 40) + 64'd1000000 / 2) / 64'd1000000),
               t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0) },
            '{ t_q'(64'd0 - ((64'd79836 << 40) + 64'd10000000000 / 2) / 64'd10000000000),
               t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0) },
            '{ t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0) },
            '{ t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0), t_q'(0) }
        }
    };

endpackage

/* sv/seawater_sound_speed_unit.sv */
// Speed of sound in seawater (UNESCO Chen-Millero) from one CTD sample per item.
// Fully pipelined: one item per cycle while the output is not stalled. The
// latency is set by the 32-stage bit-serial square root of salinity followed by
// the S^1.5 multiply and the final multiply-add; the temperature/pressure
// polynomials (eight Horner steps of a four-stage 64x64 multiply-add) run
// alongside. A stall on the output holds the whole pipeline; nothing is lost.
module seawater_sound_speed_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // salinity[16:0], temperature[33:17], pressure[51:34], zero pad
    input  logic [ssu_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // sound_speed[20:0], zero pad
    output logic [ssu_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import ssu_pkg::*;

    logic           ce;
    logic [LAT-1:0] r_vld;

    assign ce              = ~r_vld[LAT-1] | i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // input preparation
    logic [SAL_W-1:0] r_sal;
    logic [TMP_W-1:0] r_tmp;
    logic [PRS_W-1:0] r_prs;
    logic [15:0]      r_sraw;
    logic [TMP_W-1:0] r_tmp1;
    logic [50:0]      r_pm1;
    logic [17:0]      r_pm2;
    logic [19:0]      n_p3;
    logic [41:0]      n_pq;
    t_q               r_s, r_t, r_p;
    logic [63:0]      r_rx;

    always_comb begin
        n_p3 = 20'(r_prs) * 20'd3 + 20'd2;
        n_pq = 42'(n_p3) * 42'(DIV5_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sal  <= i_s_axis_tdata[SAL_W-1:0];
            r_tmp  <= i_s_axis_tdata[SAL_W+TMP_W-1:SAL_W];
            r_prs  <= i_s_axis_tdata[SAL_W+TMP_W+PRS_W-1:SAL_W+TMP_W];

            r_sraw <= r_sal[SAL_W-1] ? 16'd0 : r_sal[15:0];
            r_tmp1 <= r_tmp;
            r_pm1  <= 51'(r_prs) * 51'(P_MUL);
            r_pm2  <= n_pq[41:24];

            r_s    <= t_q'({18'd0, r_sraw, 30'd0});
            r_t    <= t_q'({{17{r_tmp1[TMP_W-1]}}, r_tmp1, 30'd0});
            r_p    <= t_q'(64'(r_pm1) + 64'(r_pm2));
            r_rx   <= {2'b00, r_sraw, 46'd0};
        end
    end

    // polynomials in T, one lane per (poly, power of P)
    t_q t_pipe   [T_DEG];
    t_q row_acc  [4][4][T_DEG+1];
    t_q p_pipe   [P_DEG];
    t_q row_dly  [4][P_DEG];
    t_q poly_acc [4][P_DEG+1];
    t_q poly_fin [4];

    assign t_pipe[0] = r_t;

    generate
        for (genvar j = 1; j < T_DEG; j++) begin : g_tdly
            ssu_delay #(.W(64), .DEPTH(QMAC_LAT)) u_tdly (
                .i_clk(i_clk), .i_ce(ce), .i_d(t_pipe[j-1]), .o_q(t_pipe[j])
            );
        end

        ssu_delay #(.W(64), .DEPTH(QMAC_LAT * T_DEG)) u_pdly0 (
            .i_clk(i_clk), .i_ce(ce), .i_d(r_p), .o_q(p_pipe[0])
        );
        for (genvar j = 1; j < P_DEG; j++) begin : g_pdly
            ssu_delay #(.W(64), .DEPTH(QMAC_LAT)) u_pdly (
                .i_clk(i_clk), .i_ce(ce), .i_d(p_pipe[j-1]), .o_q(p_pipe[j])
            );
        end

        for (genvar g = 0; g < 4; g++) begin : g_poly
            for (genvar r = 0; r < 4; r++) begin : g_row
                assign row_acc[g][r][0] = COEF[g][r][T_DEG];
                for (genvar j = 0; j < T_DEG; j++) begin : g_tstep
                    ssu_qmac u_mac (
                        .i_clk(i_clk), .i_ce(ce),
                        .i_a(row_acc[g][r][j]), .i_x(t_pipe[j]),
                        .i_k(COEF[g][r][T_DEG-1-j]),
                        .o_y(row_acc[g][r][j+1])
                    );
                end
            end

            for (genvar r = 0; r < P_DEG; r++) begin : g_rdly
                ssu_delay #(.W(64), .DEPTH(QMAC_LAT * (P_DEG - 1 - r))) u_rdly (
                    .i_clk(i_clk), .i_ce(ce),
                    .i_d(row_acc[g][r][T_DEG]), .o_q(row_dly[g][r])
                );
            end

            assign poly_acc[g][0] = row_acc[g][P_DEG][T_DEG];
            for (genvar j = 0; j < P_DEG; j++) begin : g_pstep
                ssu_qmac u_mac (
                    .i_clk(i_clk), .i_ce(ce),
                    .i_a(poly_acc[g][j]), .i_x(p_pipe[j]),
                    .i_k(row_dly[g][P_DEG-1-j]),
                    .o_y(poly_acc[g][j+1])
                );
            end

            ssu_delay #(.W(64), .DEPTH(ROOT_LAT - POLY_LAT)) u_fdly (
                .i_clk(i_clk), .i_ce(ce),
                .i_d(poly_acc[g][P_DEG]), .o_q(poly_fin[g])
            );
        end
    endgenerate

    // salinity powers
    logic [31:0] root;
    t_q          s_r, s_f, sq, s15, s2;

    ssu_isqrt u_isqrt (
        .i_clk(i_clk), .i_ce(ce), .i_x(r_rx), .o_root(root)
    );

    ssu_delay #(.W(64), .DEPTH(ROOT_STEPS)) u_sdly0 (
        .i_clk(i_clk), .i_ce(ce), .i_d(r_s), .o_q(s_r)
    );
    ssu_delay #(.W(64), .DEPTH(QMAC_LAT)) u_sdly1 (
        .i_clk(i_clk), .i_ce(ce), .i_d(s_r), .o_q(s_f)
    );

    assign sq = t_q'({20'd0, root, 12'd0});

    ssu_qmac u_s15 (
        .i_clk(i_clk), .i_ce(ce), .i_a(s_r), .i_x(sq), .i_k('0), .o_y(s15)
    );
    ssu_qmac u_s2 (
        .i_clk(i_clk), .i_ce(ce), .i_a(s_r), .i_x(s_r), .i_k('0), .o_y(s2)
    );

    // final combination
    t_q f0, f1, f2;
    t_q r_c;
    logic [63:0] n_rnd;
    logic [SPD_W-1:0] r_spd;

    ssu_qmac u_fa (
        .i_clk(i_clk), .i_ce(ce), .i_a(poly_fin[G_A]), .i_x(s_f),
        .i_k(poly_fin[G_CW]), .o_y(f0)
    );
    ssu_qmac u_fb (
        .i_clk(i_clk), .i_ce(ce), .i_a(poly_fin[G_B]), .i_x(s15), .i_k('0), .o_y(f1)
    );
    ssu_qmac u_fd (
        .i_clk(i_clk), .i_ce(ce), .i_a(poly_fin[G_D]), .i_x(s2), .i_k('0), .o_y(f2)
    );

    assign n_rnd = 64'(r_c) + (64'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c <= t_q'(f0 + f1 + f2);
            if (r_c[63] || r_c == '0) begin
                r_spd <= '0;
            end else if (|n_rnd[63:30+SPD_W]) begin
                r_spd <= SPD_MAX;
            end else begin
                r_spd <= n_rnd[30+SPD_W-1:30];
            end
        end
    end

    assign o_m_axis_tdata = OUT_TDATA_W'(r_spd);

endmodule

/* sv/ssu_delay.sv */
module ssu_delay #(
    parameter int W = 64,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_ce,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    generate
        if (DEPTH == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_sr
            logic [W-1:0] r_sr [DEPTH];
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_sr[0] <= i_d;
                    for (int i = 1; i < DEPTH; i++) begin
                        r_sr[i] <= r_sr[i-1];
                    end
                end
            end
            assign o_q = r_sr[DEPTH-1];
        end
    endgenerate

endmodule

/* sv/ssu_qmac.sv */
module ssu_qmac (
    input  logic          i_clk,
    input  logic          i_ce,
    input  ssu_pkg::t_q   i_a,
    input  ssu_pkg::t_q   i_x,
    input  ssu_pkg::t_q   i_k,
    output ssu_pkg::t_q   o_y
);
    import ssu_pkg::*;

    // y = round(a * x / 2^40) + k, sign-magnitude rounding, four stages
    logic [63:0]  n_ua, n_ux;
    logic [63:0]  r_ua, r_ux;
    logic         r_neg_a, r_neg_b, r_neg_c;
    t_q           r_k_a, r_k_b, r_k_c;
    logic [63:0]  r_pll, r_plh, r_phl, r_phh;
    logic [127:0] n_sum;
    logic         r_sat;
    logic [61:0]  r_mag;
    logic [61:0]  n_mag;
    t_q           r_y;

    always_comb begin
        n_ua = i_a[63] ? (~i_a + 64'd1) : i_a;
        n_ux = i_x[63] ? (~i_x + 64'd1) : i_x;
        n_sum = {r_phh, 64'd0}
              + {32'd0, r_plh, 32'd0}
              + {32'd0, r_phl, 32'd0}
              + {64'd0, r_pll}
              + (128'd1 << 39);
        n_mag = r_sat ? '1 : r_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ua    <= n_ua;
            r_ux    <= n_ux;
            r_neg_a <= i_a[63] ^ i_x[63];
            r_k_a   <= i_k;

            r_pll   <= r_ua[31:0]  * r_ux[31:0];
            r_plh   <= r_ua[31:0]  * r_ux[63:32];
            r_phl   <= r_ua[63:32] * r_ux[31:0];
            r_phh   <= r_ua[63:32] * r_ux[63:32];
            r_neg_b <= r_neg_a;
            r_k_b   <= r_k_a;

            r_sat   <= |n_sum[127:102];
            r_mag   <= n_sum[101:40];
            r_neg_c <= r_neg_b;
            r_k_c   <= r_k_b;

            r_y     <= r_neg_c ? t_q'(r_k_c - t_q'({2'b00, n_mag}))
                               : t_q'(r_k_c + t_q'({2'b00, n_mag}));
        end
    end

    assign o_y = r_y;

endmodule

/* sv/ssu_isqrt.sv */
module ssu_isqrt (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);
    import ssu_pkg::*;

    logic [63:0] r_x   [ROOT_STEPS];
    logic [63:0] r_res [ROOT_STEPS];

    generate
        for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
            logic [63:0] x_in, res_in, trial, n_x, n_res;

            if (i == 0) begin : g_first
                assign x_in   = i_x;
                assign res_in = '0;
            end else begin : g_next
                assign x_in   = r_x[i-1];
                assign res_in = r_res[i-1];
            end

            always_comb begin
                trial = res_in + BIT;
                if (x_in >= trial) begin
                    n_x   = x_in - trial;
                    n_res = (res_in >> 1) + BIT;
                end else begin
                    n_x   = x_in;
                    n_res = res_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_x[i]   <= n_x;
                    r_res[i] <= n_res;
                end
            end
        end
    endgenerate

    assign o_root = r_res[ROOT_STEPS-1][31:0];

endmodule

/* sv/ssu_chk.sv */
module ssu_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [ssu_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import ssu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[OUT_TDATA_W-1:SPD_W] == '0)
        else $error("output pad bits set");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind seawater_sound_speed_unit ssu_chk u_chk (.*);
